// ===== hw/rtl/sfid_pkg.sv =====
`timescale 1ns / 1ps

package sfid_pkg;

	localparam int unsigned STACK_DEPTH = 32;
	localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int unsigned ID_W        = 64;
	localparam int unsigned DEPTH_OUT_W = 6;
	localparam int unsigned SENT_LEN    = 16;
	localparam int unsigned SENT_W      = 4;

	localparam logic [ID_W-1:0] FNV_OFFSET   = 64'd1469598103934665603;
	// prime is 2^40 + 0x1B3
	localparam int unsigned     FNV_SHIFT    = 40;
	localparam logic [8:0]      FNV_PRIME_LO = 9'h1B3;

	typedef enum logic [1:0] {
		FUNC_WIDGET = 2'd0,
		FUNC_QUERY  = 2'd1,
		FUNC_PUSH   = 2'd2,
		FUNC_POP    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SENT,
		ST_POP_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic sent_step;
		logic pop_load;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_pop;
		logic is_last;
		logic need_sent;
		logic sent_done;
		logic out_free;
	} ctl_sts_t;

	function automatic logic [7:0] sentinel_byte(logic [SENT_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'h23;
			4'd1:    b = 8'h23;
			4'd2:    b = 8'h5F;
			4'd3:    b = 8'h5F;
			4'd4:    b = 8'h66;
			4'd5:    b = 8'h6C;
			4'd6:    b = 8'h75;
			4'd7:    b = 8'h78;
			4'd8:    b = 8'h5F;
			4'd9:    b = 8'h65;
			4'd10:   b = 8'h6D;
			4'd11:   b = 8'h70;
			4'd12:   b = 8'h74;
			4'd13:   b = 8'h79;
			4'd14:   b = 8'h5F;
			default: b = 8'h5F;
		endcase
		return b;
	endfunction

	// one FNV-1a round; the multiply by the prime is a shift plus a 9-bit constant product
	function automatic logic [ID_W-1:0] fnv_mix(logic [ID_W-1:0] h, logic [7:0] b);
		logic [ID_W-1:0] x;
		x = h ^ {56'd0, b};
		return (x << FNV_SHIFT) + (x * {55'd0, FNV_PRIME_LO});
	endfunction

endpackage

// ===== hw/rtl/sfid_ram.sv =====
`timescale 1ns / 1ps

module sfid_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hw/rtl/sfid_datapath.sv =====
`timescale 1ns / 1ps

module sfid_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [1:0]                         func,
	input  logic [7:0]                         byte_value,
	input  logic                               has_byte,
	input  logic                               last_byte,
	input  sfid_pkg::ctl_cmd_t                 cmd,
	output sfid_pkg::ctl_sts_t                 sts,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sfid_pkg::ID_W-1:0]          id_value,
	output logic [sfid_pkg::DEPTH_OUT_W-1:0]   stack_depth,
	output logic                               overflow
);

	import sfid_pkg::*;

	// captured word
	func_t            func_q;
	logic [7:0]       byte_q;
	logic             has_byte_q;
	logic             last_q;

	logic [ID_W-1:0]  hash_q;
	logic [ID_W-1:0]  top_q;
	logic [CNT_W-1:0] depth_q;
	logic             ovf_q;
	logic             in_string_q;
	logic             saw_q;
	logic [SENT_W-1:0] sent_cnt_q;

	logic             out_valid_q;
	logic [ID_W-1:0]  id_value_q;
	logic [DEPTH_OUT_W-1:0] stack_depth_q;
	logic             overflow_q;

	logic [ID_W-1:0]  seed;
	logic [ID_W-1:0]  h_base;
	logic [ID_W-1:0]  h_exec;
	logic [ID_W-1:0]  id_str;
	logic [ID_W-1:0]  res_id;
	logic [CNT_W-1:0] depth_dec;
	logic [CNT_W-1:0] depth_next;
	logic             ovf_next;
	logic             full;
	logic             is_push;
	logic             is_pop;
	logic             do_push;
	logic             out_free;
	logic [ID_W-1:0]  rd_data;

	assign is_push = (func_q == FUNC_PUSH);
	assign is_pop  = (func_q == FUNC_POP);
	assign full    = (depth_q == CNT_W'(STACK_DEPTH));
	assign do_push = is_push && !full;

	// top_q only holds a live entry while the stack is non-empty
	assign seed      = (depth_q == '0) ? FNV_OFFSET : top_q;
	assign h_base    = in_string_q ? hash_q : seed;
	assign h_exec    = has_byte_q ? fnv_mix(h_base, byte_q) : h_base;
	assign id_str    = (hash_q == '0) ? ID_W'(1) : hash_q;
	assign res_id    = is_pop ? seed : id_str;
	assign depth_dec = (depth_q == '0) ? depth_q : depth_q - CNT_W'(1);
	assign depth_next = do_push ? depth_q + CNT_W'(1) : depth_q;
	assign ovf_next  = ovf_q | (is_push && full);
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		sts.is_pop    = is_pop;
		sts.is_last   = last_q;
		sts.need_sent = (func_q == FUNC_WIDGET) && !saw_q && !has_byte_q;
		sts.sent_done = (sent_cnt_q == SENT_W'(SENT_LEN - 1));
		sts.out_free  = out_free;
	end

	// pop reads the entry below the old top while in EXEC; data lands for POP_RD
	sfid_ram #(
		.WIDTH (ID_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (cmd.emit && do_push),
		.wr_addr (ADDR_W'(depth_q)),
		.wr_data (id_str),
		.rd_addr (ADDR_W'(depth_dec - CNT_W'(1))),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= func_t'(func);
			byte_q     <= byte_value;
			has_byte_q <= has_byte;
			last_q     <= last_byte;
		end
		if (cmd.exec && !is_pop) begin
			hash_q <= h_exec;
		end else if (cmd.sent_step) begin
			hash_q <= fnv_mix(hash_q, sentinel_byte(sent_cnt_q));
		end
		if (cmd.pop_load) begin
			top_q <= rd_data;
		end else if (cmd.emit && do_push) begin
			top_q <= id_str;
		end
		if (cmd.emit) begin
			id_value_q    <= res_id;
			stack_depth_q <= DEPTH_OUT_W'(depth_next);
			overflow_q    <= ovf_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			ovf_q       <= 1'b0;
			in_string_q <= 1'b0;
			saw_q       <= 1'b0;
			sent_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				sent_cnt_q <= '0;
				if (is_pop) begin
					depth_q     <= depth_dec;
					in_string_q <= 1'b0;
					saw_q       <= 1'b0;
				end else if (last_q) begin
					in_string_q <= 1'b0;
					saw_q       <= 1'b0;
				end else begin
					in_string_q <= 1'b1;
					saw_q       <= saw_q | has_byte_q;
				end
			end
			if (cmd.sent_step) begin
				sent_cnt_q <= sent_cnt_q + SENT_W'(1);
			end
			if (cmd.emit) begin
				depth_q     <= depth_next;
				ovf_q       <= ovf_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign id_value    = id_value_q;
	assign stack_depth = stack_depth_q;
	assign overflow    = overflow_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond capacity");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("overflow flag dropped");

	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && do_push) |=> (top_q == $past(id_str)))
		else $error("top cache not updated on push");

endmodule

// ===== hw/rtl/sfid_ctrl.sv =====
`timescale 1ns / 1ps

module sfid_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sfid_pkg::ctl_sts_t  sts,
	output sfid_pkg::ctl_cmd_t  cmd
);

	import sfid_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_pop) begin
					state_d = ST_POP_RD;
				end else if (!sts.is_last) begin
					state_d = ST_IDLE;
				end else if (sts.need_sent) begin
					state_d = ST_SENT;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SENT: begin
				if (sts.sent_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_POP_RD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.exec      = 1'b0;
		cmd.sent_step = 1'b0;
		cmd.pop_load  = 1'b0;
		cmd.emit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_SENT: begin
				cmd.sent_step = 1'b1;
			end
			ST_POP_RD: begin
				cmd.pop_load = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EXEC))
		else $error("accepted word not executed next cycle");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded over an untaken word");

	a_sent_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SENT && sts.sent_done) |=> (state_q == ST_EMIT))
		else $error("sentinel pass did not end in emit");

endmodule

// ===== hw/rtl/scoped_fnv1a_id_stack.sv =====
`timescale 1ns / 1ps
// A result follows the mix of the word ending its string, a pop's stack RAM read, or an empty
// widget string's 16 sentinel rounds; a stalled result holds the next word.
// A word is accepted, then mixed; one ending a string is then emitted (an empty widget runs its
// sentinel rounds first); a pop is accepted, steps the count, reads the stack RAM and emits.
// The 64-bit hash goes through one shift-and-add multiplier per byte; one word is handled at a time.
// Reset (arst_n low) clears count, overflow, string state and output valid; stack RAM is not cleared.

module scoped_fnv1a_id_stack (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        func,
	input  logic [7:0]                        byte_value,
	input  logic                              has_byte,
	input  logic                              last_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sfid_pkg::ID_W-1:0]         id_value,
	output logic [sfid_pkg::DEPTH_OUT_W-1:0]  stack_depth,
	output logic                              overflow
);

	import sfid_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	sfid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfid_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (func),
		.byte_value  (byte_value),
		.has_byte    (has_byte),
		.last_byte   (last_byte),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.id_value    (id_value),
		.stack_depth (stack_depth),
		.overflow    (overflow)
	);

endmodule

// ===== sim/tb_scoped_fnv1a_id_stack.sv =====
`timescale 1ns / 1ps

module tb_scoped_fnv1a_id_stack;
	import sfid_pkg::*;

	localparam int unsigned TOTAL_WORDS    = 1275;
	localparam int unsigned CALM_AFTER     = 1120;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 40;
	localparam int unsigned MAX_REPORTS    = 10;

	localparam bit [63:0] HASH_SEED  = 64'd1469598103934665603;
	localparam bit [63:0] HASH_PRIME = 64'd1099511628211;
	// sixteen-byte tag mixed in for a widget whose string carries no byte
	localparam bit [7:0] EMPTY_TAG [16] = '{
		8'h23, 8'h23, 8'h5F, 8'h5F, 8'h66, 8'h6C, 8'h75, 8'h78,
		8'h5F, 8'h65, 8'h6D, 8'h70, 8'h74, 8'h79, 8'h5F, 8'h5F
	};

	typedef struct {
		bit [63:0] id;
		bit [5:0]  depth;
		bit        ovf;
	} id_result_t;

	class scope_id_predictor;
		bit [63:0]   scopes [STACK_DEPTH];
		int unsigned depth;
		bit          ovf;
		bit [63:0]   hash;
		bit          in_str;
		bit          saw;
		id_result_t  pending_ids [$];
		int unsigned errors;

		function bit [63:0] top_scope();
			if (depth == 0)
				return HASH_SEED;
			return scopes[depth-1];
		endfunction

		function bit [63:0] fnv_round(bit [63:0] h, bit [7:0] b);
			bit [63:0] x;
			x = h ^ {56'd0, b};
			return x * HASH_PRIME;
		endfunction

		function void queue_result(bit [63:0] id);
			id_result_t r;
			r.id = id;
			r.depth = depth[5:0];
			r.ovf = ovf;
			pending_ids.push_back(r);
		endfunction

		function void note_word(func_t f, bit [7:0] b, bit hb, bit lb);
			bit [63:0] id;
			if (f == FUNC_POP) begin
				// pop acts at once and drops any half-built string
				if (depth != 0)
					depth--;
				in_str = 0;
				saw = 0;
				queue_result(top_scope());
				return;
			end
			if (!in_str) begin
				hash = top_scope();
				in_str = 1;
				saw = 0;
			end
			if (hb) begin
				hash = fnv_round(hash, b);
				saw = 1;
			end
			if (!lb)
				return;
			id = hash;
			if (f == FUNC_WIDGET && !saw) begin
				foreach (EMPTY_TAG[i])
					id = fnv_round(id, EMPTY_TAG[i]);
			end
			if (id == 64'd0)
				id = 64'd1;
			if (f == FUNC_PUSH) begin
				if (depth >= STACK_DEPTH)
					ovf = 1;
				else begin
					scopes[depth] = id;
					depth++;
				end
			end
			in_str = 0;
			saw = 0;
			queue_result(id);
		endfunction

		function void check_result(bit [63:0] id, bit [5:0] dep, bit ov);
			id_result_t exp_r;
			if (pending_ids.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: id %h depth %0d overflow %0b", id, dep, ov);
				return;
			end
			exp_r = pending_ids.pop_front();
			if (exp_r.id !== id || exp_r.depth !== dep || exp_r.ovf !== ov) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("mismatch: expected id %h depth %0d overflow %0b, got id %h depth %0d overflow %0b",
						exp_r.id, exp_r.depth, exp_r.ovf, id, dep, ov);
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [1:0]             func = FUNC_WIDGET;
	logic [7:0]             byte_value = 8'd0;
	logic                   has_byte = 1'b0;
	logic                   last_byte = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [ID_W-1:0]        id_value;
	logic [DEPTH_OUT_W-1:0] stack_depth;
	logic                   overflow;

	scope_id_predictor sb;
	int unsigned       words_sent;
	bit                calm;
	int unsigned       stall_left;
	int unsigned       quiet_cycles = 0;

	scoped_fnv1a_id_stack dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.byte_value  (byte_value),
		.has_byte    (has_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.id_value    (id_value),
		.stack_depth (stack_depth),
		.overflow    (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stall bursts until the closing stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(id_value, stack_depth, overflow);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_scoped_fnv1a_id_stack failed");
				$finish;
			end
		end
	end

	task automatic send_word(func_t f, bit [7:0] b, bit hb, bit lb);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		byte_value <= b;
		has_byte <= hb;
		last_byte <= lb;
		do @(posedge clk); while (!in_ready);
		sb.note_word(f, b, hb, lb);
		words_sent++;
		if (words_sent >= CALM_AFTER)
			calm = 1'b1;
	endtask

	// noisy strings drop some bytes and switch func on words before the last
	task automatic send_string(func_t f, int unsigned len, bit no_bytes, bit noisy);
		bit    hb;
		func_t fi;
		for (int unsigned i = 0; i < len; i++) begin
			hb = no_bytes ? 1'b0 : (noisy ? ($urandom_range(0, 3) != 0) : 1'b1);
			fi = (noisy && i + 1 < len && $urandom_range(0, 2) == 0) ?
				func_t'($urandom_range(0, 2)) : f;
			send_word(fi, 8'($urandom_range(0, 255)), hb, i + 1 == len);
		end
	endtask

	task automatic push_integer(bit [63:0] v);
		for (int i = 0; i < 8; i++)
			send_word(FUNC_PUSH, v[8*i +: 8], 1'b1, i == 7);
	endtask

	task automatic send_pop(bit lb);
		send_word(FUNC_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), lb);
	endtask

	task automatic run_directed();
		send_pop(1'b1);                                 // pop on empty stack
		send_string(FUNC_QUERY, 1, 1'b1, 1'b0);         // empty query: seed only
		send_string(FUNC_WIDGET, 1, 1'b1, 1'b0);        // empty widget: tag
		send_word(FUNC_WIDGET, 8'h00, 1'b1, 1'b1);
		send_word(FUNC_WIDGET, 8'hFF, 1'b1, 1'b1);
		push_integer(64'h0123_4567_89AB_CDEF);
		send_string(FUNC_WIDGET, 2, 1'b1, 1'b0);        // two byteless words, under a scope
		send_word(FUNC_QUERY, 8'hA5, 1'b1, 1'b1);
		send_string(FUNC_PUSH, 1, 1'b1, 1'b0);          // push of the current top scope again
		send_word(FUNC_WIDGET, 8'h5A, 1'b1, 1'b0);      // string abandoned by a pop
		send_pop(1'b0);
		send_word(FUNC_QUERY, 8'h3C, 1'b1, 1'b0);       // func of the last word decides
		send_word(FUNC_PUSH, 8'hC3, 1'b1, 1'b1);
		send_pop(1'b1);
		send_pop(1'b1);
		send_pop(1'b1);
	endtask

	task automatic run_random();
		int unsigned action_no;
		int unsigned pick;
		int unsigned kind;
		bit          push_phase;
		func_t       f;
		action_no = 0;
		push_phase = 1'b0;
		while (words_sent < TOTAL_WORDS) begin
			// alternate push-heavy and pop-heavy stretches so the stack fills and drains
			if (action_no % 40 == 0)
				push_phase = ~push_phase;
			action_no++;
			pick = $urandom_range(0, 99);
			if (pick < (push_phase ? 5 : 45)) begin
				send_pop($urandom_range(0, 3) != 0);
				continue;
			end
			if (pick < (push_phase ? 65 : 55))
				f = FUNC_PUSH;
			else
				f = ($urandom_range(0, 1) != 0) ? FUNC_WIDGET : FUNC_QUERY;
			kind = $urandom_range(0, 19);
			if (kind == 0)
				send_word(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			else if (kind <= 2)
				send_string(f, $urandom_range(1, 3), 1'b1, 1'b0);
			else if (kind == 3 && f == FUNC_PUSH)
				push_integer({$urandom, $urandom});
			else
				send_string(f, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) :
					$urandom_range(1, 5), 1'b0, $urandom_range(0, 4) == 0);
		end
	endtask

	initial begin
		sb = new();
		words_sent = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		in_valid <= 1'b0;
		while (sb.pending_ids.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_ids.size() == 0)
			$display("tb_scoped_fnv1a_id_stack passed");
		else
			$display("tb_scoped_fnv1a_id_stack failed");
		$finish;
	end

endmodule
